### rtl/hng_pkg.sv
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types, register map, number formats and the control program of the
// noise gate sequencer.
// ----------------------------------------------------------------------------
package hng_pkg;

   // sample and state formats
   localparam int SAMPLE_W = 24;          // Q1.23
   localparam int STATE_W  = 40;          // Q1.39
   localparam int DIFF_W   = STATE_W + 1; // difference of two states
   localparam int GAIN_W   = 25;          // unsigned Q1.24
   localparam int COEF_W   = 25;          // multiplier coefficient port
   localparam int ACC_W    = 67;          // full product of diff and coef
   localparam int LO_W     = 21;          // low slice of the multiplicand
   localparam int THR_W    = 23;
   localparam int RATE_W   = 24;
   localparam int GUARD_W  = 16;          // state guard bits below the sample
   localparam int FRAC_W   = 24;          // coefficient fraction bits

   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << FRAC_W);

   // configuration register map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_GATE_ENABLE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OPEN_THRESHOLD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLOSE_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DETECTOR_ATTACK  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DETECTOR_RELEASE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_OPEN_RATE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_CLOSE_RATE  = 3'd6;

   typedef struct packed {
      logic              gate_enable;
      logic [THR_W-1:0]  open_threshold;
      logic [THR_W-1:0]  close_threshold;
      logic [RATE_W-1:0] detector_attack;
      logic [RATE_W-1:0] detector_release;
      logic [RATE_W-1:0] gain_open_rate;
      logic [RATE_W-1:0] gain_close_rate;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gate_enable:      1'b1,
      open_threshold:   THR_W'(8389),
      close_threshold:  THR_W'(3775),
      detector_attack:  RATE_W'(231414),
      detector_release: RATE_W'(1589),
      gain_open_rate:   RATE_W'(345897),
      gain_close_rate:  RATE_W'(1942)
   };

   // channel payloads
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sidechain_sample;
      logic signed [SAMPLE_W-1:0] signal_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] gated_sample;
      logic                       gate_is_open;
   } rsp_payload_type;

   // micro-operations
   typedef enum logic [2:0] {
      OP_WAIT = 3'd0,  // take an input beat, branch on gate_enable
      OP_LOAD = 3'd1,  // form difference and coefficient for src
      OP_MLO  = 3'd2,  // low partial product
      OP_MHI  = 3'd3,  // high partial product, accumulate
      OP_WB   = 3'd4,  // state of src += product / 2^24
      OP_HYST = 3'd5,  // hysteresis compare
      OP_EMIT = 3'd6   // hand result to the output register
   } op_type;

   typedef enum logic [2:0] {
      SRC_HP   = 3'd0,
      SRC_LP   = 3'd1,
      SRC_ENV  = 3'd2,
      SRC_GAIN = 3'd3,
      SRC_OUT  = 3'd4,
      SRC_PASS = 3'd5
   } src_type;

   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_START = 5'd0;
   localparam logic [PC_W-1:0] PC_PASS  = 5'd22;
   localparam logic [PC_W-1:0] PC_LAST  = 5'd22;

   typedef struct packed {
      op_type          op;
      src_type         src;
      logic [PC_W-1:0] target;
   } uword_type;

   // datapath control for one cycle
   typedef struct packed {
      op_type  op;
      src_type src;
      logic    take;
   } ctrl_type;

   function automatic uword_type uw(input op_type op, input src_type src,
                                    input logic [PC_W-1:0] target);
      uword_type w;
      w.op     = op;
      w.src    = src;
      w.target = target;
      return w;
   endfunction

   // control program: four steps per filter update, shared multiplier
   function automatic uword_type hng_ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         5'd0:    w = uw(OP_WAIT, SRC_PASS, PC_PASS);
         5'd1:    w = uw(OP_LOAD, SRC_HP,   PC_START);
         5'd2:    w = uw(OP_MLO,  SRC_HP,   PC_START);
         5'd3:    w = uw(OP_MHI,  SRC_HP,   PC_START);
         5'd4:    w = uw(OP_WB,   SRC_HP,   PC_START);
         5'd5:    w = uw(OP_LOAD, SRC_LP,   PC_START);
         5'd6:    w = uw(OP_MLO,  SRC_LP,   PC_START);
         5'd7:    w = uw(OP_MHI,  SRC_LP,   PC_START);
         5'd8:    w = uw(OP_WB,   SRC_LP,   PC_START);
         5'd9:    w = uw(OP_LOAD, SRC_ENV,  PC_START);
         5'd10:   w = uw(OP_MLO,  SRC_ENV,  PC_START);
         5'd11:   w = uw(OP_MHI,  SRC_ENV,  PC_START);
         5'd12:   w = uw(OP_WB,   SRC_ENV,  PC_START);
         5'd13:   w = uw(OP_HYST, SRC_ENV,  PC_START);
         5'd14:   w = uw(OP_LOAD, SRC_GAIN, PC_START);
         5'd15:   w = uw(OP_MLO,  SRC_GAIN, PC_START);
         5'd16:   w = uw(OP_MHI,  SRC_GAIN, PC_START);
         5'd17:   w = uw(OP_WB,   SRC_GAIN, PC_START);
         5'd18:   w = uw(OP_LOAD, SRC_OUT,  PC_START);
         5'd19:   w = uw(OP_MLO,  SRC_OUT,  PC_START);
         5'd20:   w = uw(OP_MHI,  SRC_OUT,  PC_START);
         5'd21:   w = uw(OP_EMIT, SRC_OUT,  PC_START);
         5'd22:   w = uw(OP_EMIT, SRC_PASS, PC_START);
         default: w = uw(OP_WAIT, SRC_PASS, PC_PASS);
      endcase
      return w;
   endfunction

endpackage

### rtl/hng_if.sv
// ----------------------------------------------------------------------------
// hng_if
// Ready/valid channels of the noise gate: sample input, result output and
// the register write port.
// ----------------------------------------------------------------------------
interface hng_req_if;
   import hng_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hng_rsp_if;
   import hng_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hng_csr_if;
   import hng_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/hysteresis_noise_gate.sv
// ----------------------------------------------------------------------------
// hysteresis_noise_gate
// Sidechain noise gate with hysteresis for Q1.23 audio, microcoded.
// ----------------------------------------------------------------------------
// With the gate enabled, a sample beat runs 22 program steps, from the accept
// step to the step that loads the result into the output register: the
// high-pass, low-pass, envelope and gain updates each run four steps
// (operand load, low and high partial product on the single 21x25 multiplier,
// write-back), the output scaling runs a load, two partial products and the
// hand-off, and one hysteresis step and the accept step come on top. With the
// gate disabled a beat runs only the accept step and the hand-off step. The
// hand-off step waits while the output register holds a result that has not
// been taken. The next beat is accepted while the previous result still waits
// in the output register. Register writes complete in the cycle they are
// presented; to have a write take effect on the next beat, the user writes
// while no beat is in progress, as the block itself does not enforce it.
module hysteresis_noise_gate #(
   parameter int HIGHPASS_COEF = 216776,
   parameter int LOWPASS_COEF  = 4952890
) (
   input  logic      clock,
   input  logic      reset,
   hng_req_if.sink   req_ch,
   hng_rsp_if.source rsp_ch,
   hng_csr_if.sink   csr_ch
);
   import hng_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;
   uword_type           word;
   ctrl_type            ctrl;
   logic                req_take, emit_go, csr_take;
   logic signed [SAMPLE_W-1:0] emit_sample;
   logic                gate_open;

   // register writes
   assign csr_ch.ready = !reset;
   assign csr_take     = csr_ch.valid && csr_ch.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         case (csr_ch.reg_index)
            REG_GATE_ENABLE:      cfg_in.gate_enable      = csr_ch.wdata[0];
            REG_OPEN_THRESHOLD:   cfg_in.open_threshold   = csr_ch.wdata[THR_W-1:0];
            REG_CLOSE_THRESHOLD:  cfg_in.close_threshold  = csr_ch.wdata[THR_W-1:0];
            REG_DETECTOR_ATTACK:  cfg_in.detector_attack  = csr_ch.wdata[RATE_W-1:0];
            REG_DETECTOR_RELEASE: cfg_in.detector_release = csr_ch.wdata[RATE_W-1:0];
            REG_GAIN_OPEN_RATE:   cfg_in.gain_open_rate   = csr_ch.wdata[RATE_W-1:0];
            REG_GAIN_CLOSE_RATE:  cfg_in.gain_close_rate  = csr_ch.wdata[RATE_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer: fetch, handshakes, next step
   assign word         = hng_ucode(pc_ff);
   assign req_ch.ready = (word.op == OP_WAIT) && !reset;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign emit_go      = (word.op == OP_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      pc_in = pc_ff + PC_W'(1);
      case (word.op)
         OP_WAIT: begin
            if (!req_take) begin
               pc_in = pc_ff;
            end else if (!cfg_ff.gate_enable) begin
               pc_in = word.target;
            end
         end
         OP_EMIT: pc_in = emit_go ? word.target : pc_ff;
         default: pc_in = pc_ff + PC_W'(1);
      endcase
   end

   assign ctrl.op   = word.op;
   assign ctrl.src  = word.src;
   assign ctrl.take = req_take;

   hng_datapath #(
      .HIGHPASS_COEF (HIGHPASS_COEF),
      .LOWPASS_COEF  (LOWPASS_COEF)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg_ff),
      .req_data    (req_ch.data),
      .emit_sample (emit_sample),
      .gate_open   (gate_open)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      if (emit_go) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.gated_sample = emit_sample;
         rsp_data_in.gate_is_open = gate_open;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         pc_ff        <= PC_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   ap_enabled_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && cfg_ff.gate_enable) |=> (word.op == OP_LOAD))
      else $error("enabled beat did not start the filter program");
   ap_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_LAST)
      else $error("step counter beyond the program");
   ap_emit_stall: assert property (@(posedge clock) disable iff (reset)
      (word.op == OP_EMIT && rsp_valid_ff && !rsp_ch.ready) |=> $stable(pc_ff))
      else $error("program moved on while the output register was full");
   ap_single_emit: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (word.op == OP_WAIT))
      else $error("result hand-off did not return to the accept step");
`endif

endmodule

### rtl/hng_datapath.sv
// ----------------------------------------------------------------------------
// hng_datapath
// Filter, envelope and gain state with one shared 21x25 multiplier, driven
// one micro-operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module hng_datapath #(
   parameter int HIGHPASS_COEF = 216776,
   parameter int LOWPASS_COEF  = 4952890
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hng_pkg::ctrl_type                 ctrl,
   input  hng_pkg::cfg_type                  cfg,
   input  hng_pkg::req_payload_type          req_data,
   output logic signed [hng_pkg::SAMPLE_W-1:0] emit_sample,
   output logic                              gate_open
);
   import hng_pkg::*;

   localparam logic [COEF_W-1:0] HP_C = COEF_W'(HIGHPASS_COEF);
   localparam logic [COEF_W-1:0] LP_C = COEF_W'(LOWPASS_COEF);
   localparam int HI_W = DIFF_W - LO_W;

   // captured beat
   logic signed [SAMPLE_W-1:0] sc_ff, sc_in, sig_ff, sig_in;
   // filter state
   logic signed [STATE_W-1:0]  hs_ff, hs_in, lp_ff, lp_in, env_ff, env_in;
   logic                       open_ff, open_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   // multiplier operands and accumulator
   logic signed [DIFF_W-1:0]   d_ff, d_in;
   logic [COEF_W-1:0]          c_ff, c_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;

   logic signed [DIFF_W-1:0]   x41, hs41, lp41, env41, d_hp, d_lp, mag41, d_env;
   logic signed [STATE_W-1:0]  hp_sat;
   logic signed [GAIN_W:0]     target26, gain26, d_gain;
   logic signed [DIFF_W-1:0]   q41, wb_hs, wb_lp, wb_env;
   logic signed [GAIN_W:0]     wb_gain;
   logic [LO_W-1:0]            d_lo;
   logic signed [HI_W-1:0]     d_hi;
   logic signed [LO_W+COEF_W:0]  prod_lo;
   logic signed [HI_W+COEF_W:0]  prod_hi;

   // operand forming
   always_comb begin
      x41   = {sc_ff[SAMPLE_W-1], sc_ff, GUARD_W'(0)};
      hs41  = {hs_ff[STATE_W-1], hs_ff};
      lp41  = {lp_ff[STATE_W-1], lp_ff};
      env41 = {env_ff[STATE_W-1], env_ff};
      d_hp  = x41 - hs41;
      // high-pass output saturated to the state range
      if (d_hp[DIFF_W-1] != d_hp[DIFF_W-2]) begin
         hp_sat = d_hp[DIFF_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                 : {1'b0, {(STATE_W-1){1'b1}}};
      end else begin
         hp_sat = d_hp[STATE_W-1:0];
      end
      d_lp     = {hp_sat[STATE_W-1], hp_sat} - lp41;
      mag41    = lp_ff[STATE_W-1] ? -lp41 : lp41;
      d_env    = mag41 - env41;
      target26 = open_ff ? $signed({1'b0, UNITY_GAIN}) : '0;
      gain26   = $signed({1'b0, gain_ff});
      d_gain   = target26 - gain26;
   end

   // shared multiplier, signed high slice and unsigned low slice
   always_comb begin
      d_lo    = d_ff[LO_W-1:0];
      d_hi    = d_ff[DIFF_W-1:LO_W];
      prod_lo = (LO_W+COEF_W+1)'(d_lo) * (LO_W+COEF_W+1)'(c_ff);
      prod_hi = (HI_W+COEF_W+1)'(d_hi) * $signed((HI_W+COEF_W+1)'(c_ff));
   end

   // floor(product / 2^24) and the write-back sums
   always_comb begin
      q41     = acc_ff[FRAC_W+DIFF_W-1:FRAC_W];
      wb_hs   = hs41 + q41;
      wb_lp   = lp41 + q41;
      wb_env  = env41 + q41;
      wb_gain = gain26 + q41[GAIN_W:0];
   end

   // next state per micro-operation
   always_comb begin
      sc_in   = sc_ff;
      sig_in  = sig_ff;
      hs_in   = hs_ff;
      lp_in   = lp_ff;
      env_in  = env_ff;
      open_in = open_ff;
      gain_in = gain_ff;
      d_in    = d_ff;
      c_in    = c_ff;
      acc_in  = acc_ff;
      case (ctrl.op)
         OP_WAIT: begin
            if (ctrl.take) begin
               sc_in  = req_data.sidechain_sample;
               sig_in = req_data.signal_sample;
            end
         end
         OP_LOAD: begin
            case (ctrl.src)
               SRC_HP: begin
                  d_in = d_hp;
                  c_in = HP_C;
               end
               SRC_LP: begin
                  d_in = d_lp;
                  c_in = LP_C;
               end
               SRC_ENV: begin
                  d_in = d_env;
                  c_in = (mag41 > env41) ? {1'b0, cfg.detector_attack}
                                         : {1'b0, cfg.detector_release};
               end
               SRC_GAIN: begin
                  d_in = DIFF_W'(d_gain);
                  c_in = (target26 > gain26) ? {1'b0, cfg.gain_open_rate}
                                             : {1'b0, cfg.gain_close_rate};
               end
               default: begin
                  d_in = DIFF_W'(sig_ff);
                  c_in = gain_ff;
               end
            endcase
         end
         OP_MLO: acc_in = {{(ACC_W-LO_W-COEF_W-1){1'b0}}, prod_lo};
         OP_MHI: acc_in = acc_ff + {prod_hi, LO_W'(0)};
         OP_WB: begin
            case (ctrl.src)
               SRC_HP:   hs_in   = wb_hs[STATE_W-1:0];
               SRC_LP:   lp_in   = wb_lp[STATE_W-1:0];
               SRC_ENV:  env_in  = wb_env[STATE_W-1:0];
               SRC_GAIN: gain_in = wb_gain[GAIN_W-1:0];
               default:  gain_in = gain_ff;
            endcase
         end
         OP_HYST: begin
            if (!open_ff) begin
               if (env41 >= $signed({2'b00, cfg.open_threshold, GUARD_W'(0)})) begin
                  open_in = 1'b1;
               end
            end else begin
               if (env41 < $signed({2'b00, cfg.close_threshold, GUARD_W'(0)})) begin
                  open_in = 1'b0;
               end
            end
         end
         default: open_in = open_ff;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff   <= '0;
         lp_ff   <= '0;
         env_ff  <= '0;
         open_ff <= 1'b0;
         gain_ff <= '0;
      end else begin
         hs_ff   <= hs_in;
         lp_ff   <= lp_in;
         env_ff  <= env_in;
         open_ff <= open_in;
         gain_ff <= gain_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      sc_ff  <= sc_in;
      sig_ff <= sig_in;
      d_ff   <= d_in;
      c_ff   <= c_in;
      acc_ff <= acc_in;
   end

   assign emit_sample = (ctrl.src == SRC_PASS) ? sig_ff : q41[SAMPLE_W-1:0];
   assign gate_open   = open_ff;

`ifndef NO_ASSERTIONS
   ap_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= UNITY_GAIN)
      else $error("gain above unity");
   ap_env_sign: assert property (@(posedge clock) disable iff (reset)
      !env_ff[STATE_W-1])
      else $error("envelope went negative");
   ap_open_hyst: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op != OP_HYST) |=> $stable(open_ff))
      else $error("gate flag changed outside the hysteresis step");
`endif

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the hysteresis noise gate. A driver feeds
// sample beats from a queue, a bit-exact predictor computes each result at
// acceptance, and a monitor compares every result beat against the oldest
// prediction. Register profiles change between phases while the block is
// idle; both channels are throttled at random but for the last third of the phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hng_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASES        = 12;
   localparam int BEATS_PER_SET = 36;
   localparam int HP_COEF       = 216776;
   localparam int LP_COEF       = 4952890;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;

   localparam longint STATE_MAX = (longint'(1) <<< 39) - 1;
   localparam longint STATE_MIN = -(longint'(1) <<< 39);
   localparam longint GAIN_ONE  = longint'(1) <<< FRAC_W;

   logic clock = 1'b0;
   logic reset;

   hng_req_if req_bus ();
   hng_rsp_if rsp_bus ();
   hng_csr_if csr_bus ();

   hysteresis_noise_gate #(
      .HIGHPASS_COEF (HP_COEF),
      .LOWPASS_COEF  (LP_COEF)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // stimulus and prediction stores
   req_payload_type pending_beats[$];
   rsp_payload_type expected_results[$];
   int              error_count   = 0;
   int              cycle_count   = 0;
   int              send_idle_pct = 25;
   int              recv_idle_pct = 71;

   // predictor copy of the registers and the detector state
   cfg_type gate_cfg;
   longint  hp_state;
   longint  lp_state;
   longint  env_level;
   logic    gate_open;
   longint  gain_level;

   // floor(d * c / 2^24) at full precision
   function automatic longint frac_mul(input longint d, input logic [RATE_W-1:0] c);
      logic signed [95:0] dw;
      logic signed [95:0] cw;
      logic signed [95:0] p;
      dw = 96'(d);
      cw = {72'd0, c};
      p  = dw * cw;
      return longint'(p >>> FRAC_W);
   endfunction

   // one sample through high-pass, low-pass, envelope, hysteresis and gain
   function automatic rsp_payload_type gate_step(input req_payload_type item);
      rsp_payload_type res;
      longint sc;
      longint sig;
      longint x;
      longint hp;
      longint mag;
      longint target;
      longint gated;
      sc  = longint'($signed(item.sidechain_sample));
      sig = longint'($signed(item.signal_sample));
      if (!gate_cfg.gate_enable) begin
         // pass-through, state held
         res.gated_sample = item.signal_sample;
         res.gate_is_open = gate_open;
         return res;
      end
      x = sc * 65536;
      hp_state += frac_mul(x - hp_state, RATE_W'(HP_COEF));
      hp = x - hp_state;
      if (hp > STATE_MAX) hp = STATE_MAX;
      if (hp < STATE_MIN) hp = STATE_MIN;
      lp_state += frac_mul(hp - lp_state, RATE_W'(LP_COEF));
      mag = (lp_state < 0) ? -lp_state : lp_state;
      if (mag > env_level)
         env_level += frac_mul(mag - env_level, gate_cfg.detector_attack);
      else
         env_level += frac_mul(mag - env_level, gate_cfg.detector_release);
      if (!gate_open) begin
         if (env_level >= longint'(gate_cfg.open_threshold) * 65536) gate_open = 1'b1;
      end else begin
         if (env_level < longint'(gate_cfg.close_threshold) * 65536) gate_open = 1'b0;
      end
      target = gate_open ? GAIN_ONE : 0;
      if (target > gain_level)
         gain_level += frac_mul(target - gain_level, gate_cfg.gain_open_rate);
      else
         gain_level += frac_mul(target - gain_level, gate_cfg.gain_close_rate);
      gated = (sig * gain_level) >>> FRAC_W;
      res.gated_sample = SAMPLE_W'(gated);
      res.gate_is_open = gate_open;
      return res;
   endfunction

   // sample driver: predicts at acceptance, then offers the next beat
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data  <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) expected_results.push_back(gate_step(req_bus.data));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.data  <= pending_beats.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat gated_sample %0d gate_is_open %0b",
                        $time, rsp_bus.data.gated_sample, rsp_bus.data.gate_is_open);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.data.gated_sample !== want.gated_sample) begin
                  $display("%0t: gated_sample expected %0d actual %0d",
                           $time, want.gated_sample, rsp_bus.data.gated_sample);
                  error_count++;
               end
               if (rsp_bus.data.gate_is_open !== want.gate_is_open) begin
                  $display("%0t: gate_is_open expected %0b actual %0b",
                           $time, want.gate_is_open, rsp_bus.data.gate_is_open);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("hysteresis_noise_gate regression: fail");
         $finish;
      end
   end

   function automatic void push_beat(input logic signed [SAMPLE_W-1:0] sc,
                                     input logic signed [SAMPLE_W-1:0] sig);
      req_payload_type item;
      item.sidechain_sample = sc;
      item.signal_sample    = sig;
      pending_beats.push_back(item);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] any_sample();
      return SAMPLE_W'($urandom);
   endfunction

   // log-scaled coefficient, full 24-bit range
   function automatic logic [RATE_W-1:0] rand_rate();
      int k;
      k = $urandom_range(23, 0);
      return RATE_W'((1 << k) | ($urandom & ((1 << k) - 1)));
   endfunction

   // log-scaled threshold, full 23-bit range
   function automatic logic [THR_W-1:0] rand_level();
      int k;
      k = $urandom_range(22, 0);
      return THR_W'((1 << k) | ($urandom & ((1 << k) - 1)));
   endfunction

   // one shaped stretch of sidechain material, returns the beats queued
   function automatic int add_sequence();
      int n;
      int k;
      int half;
      logic signed [SAMPLE_W-1:0] amp;
      logic pol;
      n = 0;
      case ($urandom_range(4, 0))
         0: begin
            // raw noise on both fields
            n = $urandom_range(12, 4);
            for (int i = 0; i < n; i++) push_beat(any_sample(), any_sample());
         end
         1: begin
            // near silence, lets the envelope fall and the gate close
            n = $urandom_range(40, 10);
            for (int i = 0; i < n; i++)
               push_beat(SAMPLE_W'(int'($urandom_range(6, 0)) - 3), any_sample());
         end
         2, 4: begin
            // square tone, steady or decaying through the thresholds
            n    = $urandom_range(40, 10);
            k    = $urandom_range(22, 6);
            half = $urandom_range(8, 1);
            amp  = SAMPLE_W'((1 << k) | ($urandom & ((1 << k) - 1)));
            for (int i = 0; i < n; i++) begin
               push_beat(((i / half) % 2 != 0) ? -amp : amp, any_sample());
               if (i % 4 == 3 && $urandom_range(1, 0) != 0) amp = amp >>> 1;
            end
         end
         default: begin
            // full-scale step, drives the high-pass past full scale
            n   = $urandom_range(20, 3);
            pol = 1'($urandom_range(1, 0));
            for (int i = 0; i < n; i++) push_beat(pol ? SAMPLE_MAX : SAMPLE_MIN, any_sample());
            for (int i = 0; i < 3; i++) push_beat(pol ? SAMPLE_MIN : SAMPLE_MAX, any_sample());
            n += 3;
         end
      endcase
      return n;
   endfunction

   // register profile for one phase
   function automatic cfg_type pick_profile(input int phase);
      cfg_type c;
      c.gate_enable      = 1'b1;
      c.open_threshold   = rand_level();
      c.close_threshold  = rand_level();
      c.detector_attack  = rand_rate();
      c.detector_release = rand_rate();
      c.gain_open_rate   = rand_rate();
      c.gain_close_rate  = rand_rate();
      case (phase)
         0: ;
         1: c = CFG_RESET;
         2: begin
            c.open_threshold   = THR_W'($urandom_range(4000, 0));
            c.close_threshold  = THR_W'($urandom_range(2000, 0));
            c.detector_attack  = '1;
            c.detector_release = '1;
            c.gain_open_rate   = '1;
            c.gain_close_rate  = '1;
         end
         3: c.gate_enable = 1'b0;
         4: begin
            // close level above open level
            c.open_threshold  = THR_W'($urandom_range(255, 0));
            c.close_threshold = THR_W'((1 << 22) | $urandom_range(4095, 0));
         end
         5: begin
            c.open_threshold  = '0;
            c.close_threshold = '0;
         end
         6: begin
            c.open_threshold   = '1;
            c.close_threshold  = '1;
            c.detector_attack  = '0;
            c.detector_release = '0;
            c.gain_open_rate   = '0;
            c.gain_close_rate  = '0;
         end
         7: begin
            c.detector_attack  = RATE_W'(1);
            c.detector_release = RATE_W'(1);
            c.gain_open_rate   = RATE_W'(1);
            c.gain_close_rate  = RATE_W'(1);
         end
         default: if ($urandom_range(3, 0) == 0) c.gate_enable = 1'b0;
      endcase
      return c;
   endfunction

   // wait until every queued beat is accepted and every result has come back
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_beats.size() != 0 || expected_results.size() != 0 || req_bus.valid);
   endtask

   // one register beat; valid is left high so back-to-back writes stay clean
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      do @(posedge clock);
      while (!csr_bus.ready);
      case (idx)
         REG_GATE_ENABLE:      gate_cfg.gate_enable      = data[0];
         REG_OPEN_THRESHOLD:   gate_cfg.open_threshold   = data[THR_W-1:0];
         REG_CLOSE_THRESHOLD:  gate_cfg.close_threshold  = data[THR_W-1:0];
         REG_DETECTOR_ATTACK:  gate_cfg.detector_attack  = data;
         REG_DETECTOR_RELEASE: gate_cfg.detector_release = data;
         REG_GAIN_OPEN_RATE:   gate_cfg.gain_open_rate   = data;
         REG_GAIN_CLOSE_RATE:  gate_cfg.gain_close_rate  = data;
         default: ;
      endcase
   endtask

   // write a whole profile, with junk in the unused upper bits of the enable and threshold writes
   task automatic apply_profile(input cfg_type c);
      wait_idle();
      if ($urandom_range(3, 0) == 0) csr_write(REG_UNMAPPED, CSR_DATA_W'($urandom));
      csr_write(REG_GATE_ENABLE,      {23'($urandom), c.gate_enable});
      csr_write(REG_OPEN_THRESHOLD,   {1'($urandom), c.open_threshold});
      csr_write(REG_CLOSE_THRESHOLD,  {1'($urandom), c.close_threshold});
      csr_write(REG_DETECTOR_ATTACK,  c.detector_attack);
      csr_write(REG_DETECTOR_RELEASE, c.detector_release);
      csr_write(REG_GAIN_OPEN_RATE,   c.gain_open_rate);
      csr_write(REG_GAIN_CLOSE_RATE,  c.gain_close_rate);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int n;
      gate_cfg   = CFG_RESET;
      hp_state   = 0;
      lp_state   = 0;
      env_level  = 0;
      gate_open  = 1'b0;
      gain_level = 0;

      reset             <= 1'b1;
      csr_bus.valid     <= 1'b0;
      csr_bus.reg_index <= REG_GATE_ENABLE;
      csr_bus.wdata     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes under the reset profile
      push_beat('0, '0);
      repeat (3) push_beat(SAMPLE_MAX, SAMPLE_MAX);
      push_beat(SAMPLE_MIN, SAMPLE_MAX);   // high-pass saturates low
      push_beat(SAMPLE_MIN, SAMPLE_MIN);
      push_beat(SAMPLE_MAX, SAMPLE_MIN);   // high-pass swings high, short of saturation
      push_beat('0, SAMPLE_MAX);
      push_beat('0, SAMPLE_MIN);
      push_beat(24'sd1, -24'sd1);
      push_beat(-24'sd1, 24'sd1);
      repeat (2) push_beat(SAMPLE_MAX, SAMPLE_MAX);

      // directed: pass-through holds state, masked and unmapped writes
      wait_idle();
      csr_write(REG_GATE_ENABLE, 24'hFFFFFE);
      csr_bus.valid <= 1'b0;
      push_beat(SAMPLE_MAX, SAMPLE_MIN);
      push_beat(SAMPLE_MIN, SAMPLE_MAX);
      push_beat(24'sh123456, -24'sd5);
      wait_idle();
      csr_write(REG_UNMAPPED, 24'hFFFFFF);
      csr_write(REG_GATE_ENABLE, 24'h000001);
      csr_bus.valid <= 1'b0;
      push_beat(SAMPLE_MIN, SAMPLE_MAX);
      push_beat('0, SAMPLE_MIN);
      push_beat(SAMPLE_MAX, 24'sd1);

      // random phases, each under its own register profile
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES / 3) begin
            send_idle_pct = 71;
            recv_idle_pct = 25;
         end
         if (p == 2 * PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_profile(pick_profile(p));
         n = 0;
         while (n < BEATS_PER_SET) n += add_sequence();
      end

      wait_idle();
      repeat (32) @(posedge clock);
      if (error_count == 0) begin
         $display("hysteresis_noise_gate regression: pass");
      end else begin
         $display("hysteresis_noise_gate regression: fail");
      end
      $finish;
   end

endmodule
